// ===== rtl/core/wmra_pkg.sv =====
// ----------------------------------------------------------------------------
// wmra_pkg
// Types, codes and helper functions shared by the weighted mean / RMS
// accumulator and its iterative divider and square-root units.
// ----------------------------------------------------------------------------
`default_nettype none

package wmra_pkg;

   // Item operation codes.
   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SCALE  = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_SAT    = 2'd2
   } status_type;

   // Sequencer states of the top level.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_P1,
      ST_ADD_WS,
      ST_MUL_VV,
      ST_MUL_P2,
      ST_ADD_SQ,
      ST_ADD_TW,
      ST_SC_WS_GO,
      ST_SC_WS_WAIT,
      ST_SC_SQ_GO,
      ST_SC_SQ_WAIT,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_MS_GO,
      ST_MS_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_FINISH
   } state_type;

   // Divider geometry: a 64-bit magnitude padded with eight zero bits below it.
   localparam int DIV_N_W         = 64;
   localparam int DIV_PAD         = 8;
   localparam int DIV_Q_W         = DIV_N_W + DIV_PAD;
   localparam int DIV_D_W         = 48;
   localparam int DIV_STEPS_SCALE = DIV_Q_W;
   localparam int DIV_STEPS_MEAN  = DIV_N_W;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS_SCALE + 1);

   // Square-root geometry: 32-bit radicand, 16-bit root, one root bit a step.
   localparam int SQRT_X_W   = 32;
   localparam int SQRT_R_W   = SQRT_X_W / 2;
   localparam int SQRT_STEPS = SQRT_R_W;
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

   typedef logic [DIV_CNT_W-1:0]  div_cnt_type;
   typedef logic [SQRT_CNT_W-1:0] sqrt_cnt_type;

   // Command to the divider: start a run, long (scale) or short (mean) form.
   typedef struct packed {
      logic start;
      logic scale;
   } div_cmd_type;

   // Status of an iterative unit; done pulses for one cycle.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      mag64 = a[63] ? (64'd0 - a) : a;
   endfunction

   function automatic logic [47:0] mag48(input logic signed [47:0] a);
      mag48 = a[47] ? (48'd0 - a) : a;
   endfunction

   // Signed 64-bit value from sign and magnitude, clamped.
   // Bit 64 of the result is the saturation flag.
   function automatic logic [64:0] from_mag(input logic neg, input logic [63:0] m);
      logic        sat;
      logic [63:0] val;
      sat = 1'b0;
      if (neg) begin
         if (m[63]) begin
            sat = |m[62:0];
            val = {1'b1, 63'd0};
         end else begin
            val = 64'd0 - m;
         end
      end else begin
         if (m[63]) begin
            sat = 1'b1;
            val = {1'b0, {63{1'b1}}};
         end else begin
            val = m;
         end
      end
      from_mag = {sat, val};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wmra_div.sv =====
// ----------------------------------------------------------------------------
// wmra_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// loaded with eight zero bits appended; a long run returns the full 72-bit
// quotient of the padded value, a short run the quotient of the plain value.
// ----------------------------------------------------------------------------
`default_nettype none

module wmra_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wmra_pkg::div_cmd_type            cmd,
   input  wire  [wmra_pkg::DIV_N_W-1:0]     dividend,
   input  wire  [wmra_pkg::DIV_D_W-1:0]     divisor,
   output logic [wmra_pkg::DIV_Q_W-1:0]     quotient,
   output wmra_pkg::unit_stat_type          stat
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   wmra_pkg::div_cnt_type              cnt_ff, cnt_in;
   logic [wmra_pkg::DIV_Q_W-1:0]       dq_ff, dq_in;
   logic [wmra_pkg::DIV_D_W-1:0]       rem_ff, rem_in;
   logic [wmra_pkg::DIV_D_W-1:0]       dvs_ff, dvs_in;
   logic [wmra_pkg::DIV_D_W:0]         shifted;
   logic [wmra_pkg::DIV_D_W:0]         trial;
   logic                               fits;

   always_comb begin
      shifted = {rem_ff, dq_ff[wmra_pkg::DIV_Q_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.scale ? wmra_pkg::div_cnt_type'(wmra_pkg::DIV_STEPS_SCALE)
                             : wmra_pkg::div_cnt_type'(wmra_pkg::DIV_STEPS_MEAN);
         dq_in   = {dividend, {wmra_pkg::DIV_PAD{1'b0}}};
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[wmra_pkg::DIV_Q_W-2:0], fits};
         rem_in = fits ? trial[wmra_pkg::DIV_D_W-1:0] : shifted[wmra_pkg::DIV_D_W-1:0];
         cnt_in = cnt_ff - wmra_pkg::div_cnt_type'(1);
         if (cnt_ff == wmra_pkg::div_cnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = dq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/wmra_sqrt.sv =====
// ----------------------------------------------------------------------------
// wmra_sqrt
// Digit-by-digit integer square root, rounded down, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wmra_sqrt (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [wmra_pkg::SQRT_X_W-1:0]    radicand,
   output logic [wmra_pkg::SQRT_R_W-1:0]    root,
   output wmra_pkg::unit_stat_type          stat
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   wmra_pkg::sqrt_cnt_type             cnt_ff, cnt_in;
   logic [wmra_pkg::SQRT_X_W-1:0]      x_ff, x_in;
   logic [wmra_pkg::SQRT_R_W:0]        rem_ff, rem_in;
   logic [wmra_pkg::SQRT_R_W-1:0]      root_ff, root_in;
   logic [wmra_pkg::SQRT_R_W+2:0]      rem_sh;
   logic [wmra_pkg::SQRT_R_W+2:0]      trial;
   logic [wmra_pkg::SQRT_R_W+2:0]      rem_sub;
   logic                               fits;

   always_comb begin
      rem_sh  = {rem_ff, x_ff[wmra_pkg::SQRT_X_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      fits    = (rem_sh >= trial);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = wmra_pkg::sqrt_cnt_type'(wmra_pkg::SQRT_STEPS - 1);
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in    = {x_ff[wmra_pkg::SQRT_X_W-3:0], 2'b00};
         rem_in  = fits ? rem_sub[wmra_pkg::SQRT_R_W:0] : rem_sh[wmra_pkg::SQRT_R_W:0];
         root_in = {root_ff[wmra_pkg::SQRT_R_W-2:0], fits};
         cnt_in  = cnt_ff - wmra_pkg::sqrt_cnt_type'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/weighted_mean_rms_accumulator.sv =====
// ----------------------------------------------------------------------------
// weighted_mean_rms_accumulator
// From transfer in to result, an add or remove runs two 64-step passes of
// the shared divider and, if total weight and spread allow, a 16-step root.
// A scale adds two 72-step divider passes; a clear, a rejected scale with
// zero total weight, or any item leaving zero total weight runs neither.
// Throughput: one item at a time; the next is taken once the result is staged.
// Reset (synchronous, active high) zeroes all sums, the held mean and control.
//
// Keeps total weight, weighted sum and weighted sum of squares of Q8.8
// samples, and after each item reports mean, mean square and RMS spread.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_mean_rms_accumulator (
   input  wire                clock,
   input  wire                reset,

   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [1:0]  req_mode,
   input  wire  signed [15:0] req_sample_value,
   input  wire         [15:0] req_sample_weight,

   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [15:0] rsp_mean_out,
   output logic        [31:0] rsp_mean_square_out,
   output logic        [15:0] rsp_rms_out,
   output logic               rsp_rms_valid,
   output logic        [1:0]  rsp_status
);

   // Clamp limits of the saturating adder, held in 65 bits so that the
   // raw sum of two 64-bit operands can be compared directly.
   localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] SUM_LO = 65'sh1_8000_0000_0000_0000;
   localparam logic signed [64:0] TW_HI  = 65'sh0_0000_7FFF_FFFF_FFFF;
   localparam logic signed [64:0] TW_LO  = 65'sh1_FFFF_8000_0000_0000;

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   wmra_pkg::state_type     state_ff, state_in;
   wmra_pkg::mode_type      mode_ff, mode_in;
   logic signed [15:0]      value_ff, value_in;
   logic        [15:0]      weight_ff, weight_in;
   logic signed [48:0]      prod_ff, prod_in;

   // Accumulators, Q.8 weight, Q.16 sum and Q.24 square sum.
   logic signed [47:0]      tw_ff, tw_in;
   logic signed [63:0]      ws_ff, ws_in;
   logic signed [63:0]      wss_ff, wss_in;
   logic signed [15:0]      held_ff, held_in;

   // Per-item results gathered before they are staged at the output.
   logic        [63:0]      sm_ff, sm_in;
   logic        [31:0]      ms_ff, ms_in;
   logic        [15:0]      rms_ff, rms_in;
   logic                    valid_ff, valid_in;
   logic                    sat_ff, sat_in;
   logic                    reject_ff, reject_in;

   // Output stage.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]      rsp_mean_ff, rsp_mean_in;
   logic        [31:0]      rsp_ms_ff, rsp_ms_in;
   logic        [15:0]      rsp_rms_ff, rsp_rms_in;
   logic                    rsp_rv_ff, rsp_rv_in;
   wmra_pkg::status_type    rsp_status_ff, rsp_status_in;

   // ------------------------------------------------------------------
   // Shared multiplier: v*w, v*v, (v*v)*w and held*held, one per cycle,
   // each product registered in prod_ff before it is used.
   // ------------------------------------------------------------------
   logic signed [31:0]      mul_a;
   logic signed [16:0]      mul_b;
   logic signed [48:0]      mul_p;

   always_comb begin
      case (state_ff)
         wmra_pkg::ST_MUL_P1: begin
            mul_a = 32'(value_ff);
            mul_b = $signed({1'b0, weight_ff});
         end
         wmra_pkg::ST_MUL_VV: begin
            mul_a = 32'(value_ff);
            mul_b = 17'(value_ff);
         end
         wmra_pkg::ST_MUL_P2: begin
            mul_a = $signed(prod_ff[31:0]);
            mul_b = $signed({1'b0, weight_ff});
         end
         default: begin
            mul_a = 32'(held_ff);
            mul_b = 17'(held_ff);
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // ------------------------------------------------------------------
   // Shared saturating adder for the three accumulators. A removal adds
   // the negated product or weight.
   // ------------------------------------------------------------------
   logic signed [63:0]      add_a, add_b, add_mag;
   logic signed [64:0]      add_sum, add_hi, add_lo;
   logic signed [63:0]      add_res;
   logic                    add_sat;
   logic                    removing;

   always_comb begin
      removing = (mode_ff == wmra_pkg::MODE_REMOVE);
      case (state_ff)
         wmra_pkg::ST_ADD_TW: begin
            add_a   = 64'(tw_ff);
            add_mag = $signed({48'd0, weight_ff});
            add_hi  = TW_HI;
            add_lo  = TW_LO;
         end
         wmra_pkg::ST_ADD_SQ: begin
            add_a   = wss_ff;
            add_mag = 64'(prod_ff);
            add_hi  = SUM_HI;
            add_lo  = SUM_LO;
         end
         default: begin
            add_a   = ws_ff;
            add_mag = 64'(prod_ff);
            add_hi  = SUM_HI;
            add_lo  = SUM_LO;
         end
      endcase
      add_b   = removing ? -add_mag : add_mag;
      add_sum = 65'(add_a) + 65'(add_b);
      if (add_sum > add_hi) begin
         add_res = add_hi[63:0];
         add_sat = 1'b1;
      end else if (add_sum < add_lo) begin
         add_res = add_lo[63:0];
         add_sat = 1'b1;
      end else begin
         add_res = add_sum[63:0];
         add_sat = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Divider and square-root units
   // ------------------------------------------------------------------
   wmra_pkg::div_cmd_type                div_cmd;
   logic [wmra_pkg::DIV_N_W-1:0]         div_dividend;
   logic [wmra_pkg::DIV_D_W-1:0]         div_divisor;
   logic [wmra_pkg::DIV_Q_W-1:0]         div_q;
   wmra_pkg::unit_stat_type              div_stat;

   logic                                 sqrt_start;
   logic [wmra_pkg::SQRT_R_W-1:0]        sqrt_root;
   wmra_pkg::unit_stat_type              sqrt_stat;

   wmra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .stat     (div_stat)
   );

   // The spread sm - m2 is formed once the mean square is known; m2 is the
   // square of the reported mean, left in prod_ff by the multiplier.
   logic [64:0]             spread;

   assign spread = {1'b0, sm_ff} - {33'd0, prod_ff[31:0]};

   wmra_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (spread[wmra_pkg::SQRT_X_W-1:0]),
      .root     (sqrt_root),
      .stat     (sqrt_stat)
   );

   // ------------------------------------------------------------------
   // Sequencer and datapath next values
   // ------------------------------------------------------------------
   logic [63:0]             scaled;
   logic [64:0]             scaled_fix;
   logic [63:0]             quot;
   logic                    mean_neg;
   logic                    sq_neg;

   always_comb begin
      // Scaled magnitude clamps to all ones when it needs more than 64 bits.
      scaled     = (|div_q[wmra_pkg::DIV_Q_W-1:wmra_pkg::DIV_N_W]) ? '1
                                                                  : div_q[63:0];
      quot       = div_q[63:0];
      mean_neg   = ws_ff[63] ^ tw_ff[47];
      sq_neg     = (wss_ff[63] ^ tw_ff[47]) && (sm_ff != '0);
      scaled_fix = wmra_pkg::from_mag(state_ff == wmra_pkg::ST_SC_WS_WAIT ? ws_ff[63]
                                                                          : wss_ff[63],
                                      scaled);

      state_in      = state_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      weight_in     = weight_ff;
      prod_in       = prod_ff;
      tw_in         = tw_ff;
      ws_in         = ws_ff;
      wss_in        = wss_ff;
      held_in       = held_ff;
      sm_in         = sm_ff;
      ms_in         = ms_ff;
      rms_in        = rms_ff;
      valid_in      = valid_ff;
      sat_in        = sat_ff;
      reject_in     = reject_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_ms_in     = rsp_ms_ff;
      rsp_rms_in    = rsp_rms_ff;
      rsp_rv_in     = rsp_rv_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      div_cmd       = '0;
      div_dividend  = wmra_pkg::mag64(ws_ff);
      div_divisor   = wmra_pkg::mag48(tw_ff);
      sqrt_start    = 1'b0;

      unique case (state_ff)
         wmra_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in   = wmra_pkg::mode_type'(req_mode);
               value_in  = req_sample_value;
               weight_in = req_sample_weight;
               sat_in    = 1'b0;
               reject_in = 1'b0;
               unique case (wmra_pkg::mode_type'(req_mode))
                  wmra_pkg::MODE_ADD,
                  wmra_pkg::MODE_REMOVE: begin
                     state_in = wmra_pkg::ST_MUL_P1;
                  end
                  wmra_pkg::MODE_SCALE: begin
                     // A factor of zero or below leaves the sums alone.
                     if (req_sample_value[15] || (req_sample_value == '0)) begin
                        reject_in = 1'b1;
                        state_in  = wmra_pkg::ST_MEAN_GO;
                     end else begin
                        state_in  = wmra_pkg::ST_SC_WS_GO;
                     end
                  end
                  wmra_pkg::MODE_CLEAR: begin
                     tw_in    = '0;
                     ws_in    = '0;
                     wss_in   = '0;
                     held_in  = '0;
                     state_in = wmra_pkg::ST_MEAN_GO;
                  end
                  default: begin
                     state_in = wmra_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         wmra_pkg::ST_MUL_P1: begin
            prod_in  = mul_p;
            state_in = wmra_pkg::ST_ADD_WS;
         end

         wmra_pkg::ST_ADD_WS: begin
            ws_in    = add_res;
            sat_in   = sat_ff | add_sat;
            state_in = wmra_pkg::ST_MUL_VV;
         end

         wmra_pkg::ST_MUL_VV: begin
            prod_in  = mul_p;
            state_in = wmra_pkg::ST_MUL_P2;
         end

         wmra_pkg::ST_MUL_P2: begin
            prod_in  = mul_p;
            state_in = wmra_pkg::ST_ADD_SQ;
         end

         wmra_pkg::ST_ADD_SQ: begin
            wss_in   = add_res;
            sat_in   = sat_ff | add_sat;
            state_in = wmra_pkg::ST_ADD_TW;
         end

         wmra_pkg::ST_ADD_TW: begin
            tw_in    = add_res[47:0];
            sat_in   = sat_ff | add_sat;
            state_in = wmra_pkg::ST_MEAN_GO;
         end

         // Scale: each sum becomes trunc(sum * 256 / factor) on magnitudes.
         wmra_pkg::ST_SC_WS_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.scale = 1'b1;
            div_divisor   = {32'd0, value_ff};
            state_in      = wmra_pkg::ST_SC_WS_WAIT;
         end

         wmra_pkg::ST_SC_WS_WAIT: begin
            if (div_stat.done) begin
               ws_in    = scaled_fix[63:0];
               sat_in   = sat_ff | scaled_fix[64];
               state_in = wmra_pkg::ST_SC_SQ_GO;
            end
         end

         wmra_pkg::ST_SC_SQ_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.scale = 1'b1;
            div_dividend  = wmra_pkg::mag64(wss_ff);
            div_divisor   = {32'd0, value_ff};
            state_in      = wmra_pkg::ST_SC_SQ_WAIT;
         end

         wmra_pkg::ST_SC_SQ_WAIT: begin
            if (div_stat.done) begin
               wss_in   = scaled_fix[63:0];
               sat_in   = sat_ff | scaled_fix[64];
               state_in = wmra_pkg::ST_MEAN_GO;
            end
         end

         // With no weight the mean holds and nothing else is meaningful.
         wmra_pkg::ST_MEAN_GO: begin
            if (tw_ff == '0) begin
               ms_in    = '0;
               rms_in   = '0;
               valid_in = 1'b0;
               state_in = wmra_pkg::ST_FINISH;
            end else begin
               div_cmd.start = 1'b1;
               state_in      = wmra_pkg::ST_MEAN_WAIT;
            end
         end

         wmra_pkg::ST_MEAN_WAIT: begin
            if (div_stat.done) begin
               if (mean_neg) begin
                  held_in = (quot >= 64'd32768) ? 16'sh8000 : $signed(16'd0 - quot[15:0]);
               end else begin
                  held_in = (quot >= 64'd32767) ? 16'sh7FFF : $signed(quot[15:0]);
               end
               state_in = wmra_pkg::ST_MS_GO;
            end
         end

         // The multiplier squares the fresh mean while the divider runs.
         wmra_pkg::ST_MS_GO: begin
            div_cmd.start = 1'b1;
            div_dividend  = wmra_pkg::mag64(wss_ff);
            prod_in       = mul_p;
            state_in      = wmra_pkg::ST_MS_WAIT;
         end

         wmra_pkg::ST_MS_WAIT: begin
            if (div_stat.done) begin
               sm_in    = quot;
               state_in = wmra_pkg::ST_ROOT_GO;
            end
         end

         wmra_pkg::ST_ROOT_GO: begin
            rms_in   = '0;
            valid_in = 1'b0;
            state_in = wmra_pkg::ST_FINISH;
            if (sq_neg) begin
               // A negative mean square reads as zero.
               ms_in = '0;
            end else begin
               ms_in = (|sm_ff[63:32]) ? '1 : sm_ff[31:0];
               if (!spread[64]) begin
                  valid_in = 1'b1;
                  if (|spread[63:32]) begin
                     // A spread of 2^32 or more has a root beyond 16 bits.
                     rms_in = '1;
                  end else begin
                     sqrt_start = 1'b1;
                     state_in   = wmra_pkg::ST_ROOT_WAIT;
                  end
               end
            end
         end

         wmra_pkg::ST_ROOT_WAIT: begin
            if (sqrt_stat.done) begin
               rms_in   = sqrt_root;
               state_in = wmra_pkg::ST_FINISH;
            end
         end

         // Stage the result once the output register is free.
         wmra_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = held_ff;
               rsp_ms_in     = ms_ff;
               rsp_rms_in    = rms_ff;
               rsp_rv_in     = valid_ff;
               rsp_status_in = sat_ff    ? wmra_pkg::STATUS_SAT :
                               reject_ff ? wmra_pkg::STATUS_REJECT :
                                           wmra_pkg::STATUS_OK;
               state_in      = wmra_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wmra_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff        <= '0;
         ws_ff        <= '0;
         wss_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tw_ff        <= tw_in;
         ws_ff        <= ws_in;
         wss_ff       <= wss_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      weight_ff     <= weight_in;
      prod_ff       <= prod_in;
      sm_ff         <= sm_in;
      ms_ff         <= ms_in;
      rms_ff        <= rms_in;
      valid_ff      <= valid_in;
      sat_ff        <= sat_in;
      reject_ff     <= reject_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_ms_ff     <= rsp_ms_in;
      rsp_rms_ff    <= rsp_rms_in;
      rsp_rv_ff     <= rsp_rv_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------
   assign req_stall           = (state_ff != wmra_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mean_out        = rsp_mean_ff;
   assign rsp_mean_square_out = rsp_ms_ff;
   assign rsp_rms_out         = rsp_rms_ff;
   assign rsp_rms_valid       = rsp_rv_ff;
   assign rsp_status          = rsp_status_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_rms_zero_when_invalid : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_rms_valid) |-> (rsp_rms_out == '0))
      else $error("RMS output nonzero while flagged invalid");

   a_status_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status[0] && rsp_status[1]))
      else $error("saturation and rejection reported together");

   a_units_quiet_in_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmra_pkg::ST_IDLE) |-> (!div_stat.busy && !sqrt_stat.busy))
      else $error("arithmetic unit still running while idle");

   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again directly after a transfer");

   a_no_weight_no_rms : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == wmra_pkg::ST_FINISH) && (tw_ff == '0)) |-> !valid_ff)
      else $error("RMS flagged valid with zero total weight");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Weighted mean / RMS accumulator testbench
// Drives add, remove, scale and clear transfers into the accumulator and
// checks every result against a typed value or a cycle-free software copy
// of its arithmetic. A short table of directed transfers comes first, then
// random traffic in three phases with varying idle and stall on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wmra_pkg::*;

   // One result transfer, field for field as it leaves the block.
   typedef struct packed {
      logic signed [15:0] mean;
      logic        [31:0] mean_square;
      logic        [15:0] rms;
      logic               rms_valid;
      status_type         status;
   } result_t;

   // One row of the directed table. When check_typed is set, the result
   // written in the row is what the block must return; otherwise the
   // software copy of the block decides.
   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] value;
      logic        [15:0] weight;
      logic               check_typed;
      result_t            result;
   } stimulus_row_t;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PER_PASS = 217;
   localparam int LONG_HOLD       = 600;
   localparam int SETTLE_CYCLES   = 400;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_ROWS   = 25;

   localparam logic signed [63:0] TW_HI  = 64'sd140737488355327;
   localparam logic signed [63:0] TW_LO  = -TW_HI - 64'sd1;
   localparam logic signed [63:0] SUM_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_LO = 64'sh8000_0000_0000_0000;

   localparam result_t ALL_ZERO      = '{16'sd0, 32'd0, 16'd0, 1'b0, STATUS_OK};
   localparam result_t ZERO_REJECTED = '{16'sd0, 32'd0, 16'd0, 1'b0, STATUS_REJECT};

   // Directed transfers: zero-weight items on empty sums, rejected scale
   // factors, a clean unit sample, a symmetric pair with a known spread,
   // the field extremes driven into saturation by repeated scale-by-one,
   // negative total weight, a negative mean square, a mean square below the
   // squared mean, and a mean that holds once the total weight returns to zero.
   stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
      '{MODE_ADD,    16'sd0,     16'd0,     1'b1, ALL_ZERO},
      '{MODE_SCALE,  16'sd0,     16'd0,     1'b1, ZERO_REJECTED},
      '{MODE_SCALE,  16'sh8000,  16'hFFFF,  1'b1, ZERO_REJECTED},
      '{MODE_REMOVE, 16'sd0,     16'd0,     1'b1, ALL_ZERO},
      '{MODE_CLEAR,  16'sh7FFF,  16'hFFFF,  1'b1, ALL_ZERO},
      '{MODE_ADD,    16'sd256,   16'd256,   1'b1,
        '{16'sd256, 32'd65536, 16'd0, 1'b1, STATUS_OK}},
      '{MODE_ADD,    -16'sd256,  16'd256,   1'b1,
        '{16'sd0, 32'd65536, 16'd256, 1'b1, STATUS_OK}},
      '{MODE_SCALE,  -16'sd1,    16'd0,     1'b1,
        '{16'sd0, 32'd65536, 16'd256, 1'b1, STATUS_REJECT}},
      '{MODE_SCALE,  16'sd512,   16'd0,     1'b0, ALL_ZERO},
      '{MODE_CLEAR,  16'sd0,     16'd0,     1'b1, ALL_ZERO},
      '{MODE_ADD,    16'sh7FFF,  16'hFFFF,  1'b0, ALL_ZERO},
      '{MODE_ADD,    16'sh8000,  16'hFFFF,  1'b0, ALL_ZERO},
      '{MODE_REMOVE, 16'sh7FFF,  16'hFFFF,  1'b0, ALL_ZERO},
      '{MODE_SCALE,  16'sh7FFF,  16'd0,     1'b0, ALL_ZERO},
      '{MODE_SCALE,  16'sd1,     16'd0,     1'b0, ALL_ZERO},
      '{MODE_SCALE,  16'sd1,     16'd0,     1'b0, ALL_ZERO},
      '{MODE_SCALE,  16'sd1,     16'd0,     1'b0, ALL_ZERO},
      '{MODE_SCALE,  16'sd1,     16'hFFFF,  1'b0, ALL_ZERO},
      '{MODE_CLEAR,  16'sh8000,  16'd0,     1'b1, ALL_ZERO},
      '{MODE_REMOVE, 16'sd256,   16'd256,   1'b0, ALL_ZERO},
      '{MODE_ADD,    16'sd0,     16'd512,   1'b0, ALL_ZERO},
      '{MODE_CLEAR,  16'sd0,     16'd0,     1'b1, ALL_ZERO},
      '{MODE_ADD,    16'sd256,   16'd512,   1'b0, ALL_ZERO},
      '{MODE_REMOVE, 16'sd0,     16'd256,   1'b0, ALL_ZERO},
      '{MODE_REMOVE, 16'sd0,     16'd256,   1'b1,
        '{16'sd512, 32'd0, 16'd0, 1'b0, STATUS_OK}}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic        [1:0]  req_mode = MODE_ADD;
   logic signed [15:0] req_sample_value = 16'sd0;
   logic        [15:0] req_sample_weight = 16'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_mean_out;
   logic        [31:0] rsp_mean_square_out;
   logic        [15:0] rsp_rms_out;
   logic               rsp_rms_valid;
   logic        [1:0]  rsp_status;

   // Software copy of the accumulator state.
   logic signed [63:0] total_weight_acc;
   logic signed [63:0] value_sum_acc;
   logic signed [63:0] square_sum_acc;
   logic signed [15:0] mean_held;

   result_t     pending_results [$];
   logic [31:0] added_samples [$];  // {value, weight} of recent adds not yet removed, at most 16
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          idle_pct = 0;         // sender side, used only by the stimulus
   int          stall_pct = 0;        // receiver side
   logic        hold_request = 1'b0;
   logic        hold_served = 1'b0;
   int          hold_cycles = 0;

   always #1 clock = ~clock;

   weighted_mean_rms_accumulator i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_sample_value    (req_sample_value),
      .req_sample_weight   (req_sample_weight),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mean_out        (rsp_mean_out),
      .rsp_mean_square_out (rsp_mean_square_out),
      .rsp_rms_out         (rsp_rms_out),
      .rsp_rms_valid       (rsp_rms_valid),
      .rsp_status          (rsp_status)
   );

   // ------------------------------------------------------------------------
   // Arithmetic of the accumulator, kept free of any timing.
   // ------------------------------------------------------------------------

   function automatic logic [63:0] magnitude(input logic signed [63:0] a);
      return (a < 0) ? 64'(-a) : 64'(a);
   endfunction

   // Adds b to a and clamps to [lo, hi]. The sum is formed two bits wider so
   // that it cannot wrap before the comparison.
   function automatic logic signed [63:0] clamped_add(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic signed [63:0] lo,
                                                      input logic signed [63:0] hi,
                                                      inout bit clamped);
      logic signed [65:0] wide;
      wide = a + b;
      if (wide > hi) begin
         clamped = 1'b1;
         return hi;
      end
      if (wide < lo) begin
         clamped = 1'b1;
         return lo;
      end
      return wide[63:0];
   endfunction

   // sum * 256 / factor, truncated toward zero, on sign and magnitude.
   // A magnitude of exactly 2^63 is legal only on the negative side.
   function automatic logic signed [63:0] scaled_sum(input logic signed [63:0] sum,
                                                     input logic [63:0] factor,
                                                     inout bit clamped);
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] res;
      mag = magnitude(sum);
      quo = mag / factor;
      rem = mag % factor;
      if (quo > (64'hFFFF_FFFF_FFFF_FFFF >> 8)) res = 64'hFFFF_FFFF_FFFF_FFFF;
      else res = (quo << 8) + ((rem << 8) / factor);
      if (sum < 0) begin
         if (res >= 64'h8000_0000_0000_0000) begin
            if (res != 64'h8000_0000_0000_0000) clamped = 1'b1;
            return SUM_LO;
         end
         return -$signed(res);
      end
      if (res > 64'h7FFF_FFFF_FFFF_FFFF) begin
         clamped = 1'b1;
         return SUM_HI;
      end
      return $signed(res);
   endfunction

   // Integer square root, rounded down, two radicand bits per step.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest = x;
      root = 64'd0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Applies one item to the state copy and returns the result it causes.
   function automatic result_t apply_item(input mode_type mode,
                                          input logic signed [15:0] value,
                                          input logic [15:0] weight);
      logic signed [63:0] v64;
      logic signed [63:0] w64;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      logic signed [63:0] held64;
      logic        [63:0] tw_mag;
      logic        [63:0] mean_mag;
      logic        [63:0] square_mag;
      logic        [63:0] mean_sq;
      logic        [63:0] root;
      bit                 clamped;
      bit                 tw_neg;
      bit                 mean_neg;
      bit                 square_neg;
      result_t            r;
      v64 = value;
      w64 = {48'd0, weight};
      clamped = 1'b0;
      r = ALL_ZERO;

      case (mode)
         MODE_ADD, MODE_REMOVE: begin
            p1 = v64 * w64;
            p2 = v64 * v64 * w64;
            if (mode == MODE_REMOVE) begin
               p1 = -p1;
               p2 = -p2;
               w64 = -w64;
            end
            value_sum_acc = clamped_add(value_sum_acc, p1, SUM_LO, SUM_HI, clamped);
            square_sum_acc = clamped_add(square_sum_acc, p2, SUM_LO, SUM_HI, clamped);
            total_weight_acc = clamped_add(total_weight_acc, w64, TW_LO, TW_HI, clamped);
         end
         MODE_SCALE: begin
            // Only the two sums are scaled; the total weight stays as it is.
            if (value <= 0) begin
               r.status = STATUS_REJECT;
            end else begin
               value_sum_acc = scaled_sum(value_sum_acc, 64'(v64), clamped);
               square_sum_acc = scaled_sum(square_sum_acc, 64'(v64), clamped);
            end
         end
         default: begin
            total_weight_acc = 64'sd0;
            value_sum_acc = 64'sd0;
            square_sum_acc = 64'sd0;
            mean_held = 16'sd0;
         end
      endcase
      if (clamped) r.status = STATUS_SAT;

      // With no weight the mean repeats its last value and nothing else holds.
      if (total_weight_acc != 0) begin
         tw_mag = magnitude(total_weight_acc);
         tw_neg = total_weight_acc < 0;
         mean_mag = magnitude(value_sum_acc) / tw_mag;
         mean_neg = (value_sum_acc < 0) != tw_neg;
         if (mean_neg) mean_held = (mean_mag >= 64'd32768) ? 16'sh8000 : 16'd0 - mean_mag[15:0];
         else mean_held = (mean_mag >= 64'd32767) ? 16'sh7FFF : mean_mag[15:0];

         square_mag = magnitude(square_sum_acc) / tw_mag;
         square_neg = ((square_sum_acc < 0) != tw_neg) && (square_mag != 0);
         if (!square_neg) begin
            held64 = mean_held;
            mean_sq = 64'(held64 * held64);
            r.mean_square = (square_mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : square_mag[31:0];
            if (square_mag >= mean_sq) begin
               root = floor_sqrt(square_mag - mean_sq);
               r.rms = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
               r.rms_valid = 1'b1;
            end
         end
      end
      r.mean = mean_held;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. A transfer is offered after a random idle gap, held until
   // the block stops stalling, and only then applied to the state copy, so
   // the expectations line up with what the block actually accepted.
   // ------------------------------------------------------------------------
   task automatic send_item(input mode_type mode, input logic signed [15:0] value,
                            input logic [15:0] weight, input bit use_typed,
                            input result_t typed_result);
      result_t predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sample_value <= value;
      req_sample_weight <= weight;
      do @(posedge clock); while (req_stall);
      predicted = apply_item(mode, value, weight);
      pending_results.push_back(use_typed ? typed_result : predicted);
   endtask

   // Lowers valid and waits until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      mode_type           mode;
      logic signed [15:0] value;
      logic        [15:0] weight;
      int                 pick;
      int                 slot;

      total_weight_acc = 64'sd0;
      value_sum_acc = 64'sd0;
      square_sum_acc = 64'sd0;
      mean_held = 16'sd0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed table runs with no idling on either side.
      foreach (directed_rows[i])
         send_item(directed_rows[i].mode, directed_rows[i].value, directed_rows[i].weight,
                   directed_rows[i].check_typed, directed_rows[i].result);
      drain_results();

      // Three random passes: a busy sender with a slow receiver, then the
      // reverse, then both at full speed. The last pass also gets one long
      // receiver hold so the block backs up into its request port.
      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               idle_pct = 31;
               stall_pct <= 70;
            end
            1: begin
               idle_pct = 70;
               stall_pct <= 31;
            end
            default: begin
               idle_pct = 0;
               stall_pct <= 0;
               hold_request <= 1'b1;
            end
         endcase

         for (int n = 0; n < RANDOM_PER_PASS; n++) begin
            pick = $urandom_range(99);
            value = 16'($urandom);
            weight = 16'($urandom);
            case ($urandom_range(19))
               0:       weight = 16'd0;
               1:       weight = 16'hFFFF;
               2, 3, 4: weight = 16'($urandom_range(1, 255));
               default: ;
            endcase

            if (pick < 60) begin
               mode = MODE_ADD;
               added_samples.push_back({value, weight});
               if (added_samples.size() > 16) void'(added_samples.pop_front());
            end else if (pick < 80) begin
               // Most removals take back a sample that was added earlier so the
               // sums stay meaningful; the rest remove arbitrary samples.
               mode = MODE_REMOVE;
               if (added_samples.size() != 0 && $urandom_range(3) != 0) begin
                  slot = $urandom_range(added_samples.size() - 1);
                  {value, weight} = added_samples[slot];
                  added_samples.delete(slot);
               end
            end else if (pick < 94) begin
               mode = MODE_SCALE;
               case ($urandom_range(9))
                  0:       value = 16'(-int'($urandom_range(32768)));
                  1:       value = 16'($urandom_range(1, 127));
                  2:       ;
                  default: value = 16'($urandom_range(128, 1024));
               endcase
            end else begin
               mode = MODE_CLEAR;
               added_samples.delete();
            end
            send_item(mode, value, weight, 1'b0, ALL_ZERO);
         end
         // The sender pauses here until every outstanding result is back.
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side. Stall is random at the current rate, except for one long
   // hold, counted down here, once the stimulus asks for it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (hold_request && !hold_served) begin
         rsp_stall <= 1'b1;
         hold_cycles <= LONG_HOLD;
         hold_served <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Each accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      result_t observed;
      result_t wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         observed = '{rsp_mean_out, rsp_mean_square_out, rsp_rms_out, rsp_rms_valid,
                      status_type'(rsp_status)};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: result transfer with nothing expected: mean %0d ms %0d rms %0d",
                        $realtime, observed.mean, observed.mean_square, observed.rms);
         end else begin
            wanted = pending_results.pop_front();
            if (observed.mean !== wanted.mean || observed.mean_square !== wanted.mean_square ||
                observed.rms !== wanted.rms || observed.rms_valid !== wanted.rms_valid ||
                observed.status !== wanted.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: result mismatch", $realtime);
                  $display("   expected mean %0d ms %0d rms %0d rms_valid %0d status %0d",
                           wanted.mean, wanted.mean_square, wanted.rms, wanted.rms_valid,
                           wanted.status);
                  $display("   actual   mean %0d ms %0d rms %0d rms_valid %0d status %0d",
                           observed.mean, observed.mean_square, observed.rms,
                           observed.rms_valid, observed.status);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
rtl/core/wmra_pkg.sv
rtl/core/wmra_div.sv
rtl/core/wmra_sqrt.sv
rtl/core/weighted_mean_rms_accumulator.sv
tb/testbench.sv
